>>> rtl/core/ms_pkg.sv
// Package for the merge sorter: default sizes and the command and status
// groups that pass between controller and datapath. No dependencies.
package ms_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // store or drop the input beat
        logic sort_init;  // run width to one, source store to the element RAM
        logic lo_zero;    // first run of a pass
        logic run_init;   // set up indices of the current run pair
        logic merge_wr;   // write one merged element, advance indices
        logic lo_next;    // step to the next run pair
        logic pass_next;  // double run width, swap source and destination
        logic out_init;   // output index to zero
        logic out_rd;     // read port zero at the output index
        logic out_load;   // capture read data into the output register
        logic out_next;   // advance output index
        logic clear;      // empty the store after a burst
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic width_lt_n; // another pass is needed
        logic lo_lt_n;    // another run pair remains in this pass
        logic run_end;    // the element being merged closes the run pair
        logic out_last;   // the element being shown is the last one
    } sts_t;

endpackage

>>> rtl/core/ms_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module ms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

>>> rtl/core/ms_ctrl.sv
// Controller of the merge sorter: load, merge passes and output burst.
// Depends on ms_pkg for the command and status groups.
module ms_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         last,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  ms_pkg::sts_t sts,
    output ms_pkg::cmd_t cmd
);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_PASS = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_MRD  = 3'd3;
    localparam logic [2:0] S_MWR  = 3'd4;
    localparam logic [2:0] S_ORD  = 3'd5;
    localparam logic [2:0] S_OLD  = 3'd6;
    localparam logic [2:0] S_OWT  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall  = (state_reg != S_LOAD);
    assign out_valid = (state_reg == S_OWT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD:
            begin
                cmd.load = in_valid;
                if (in_valid && last)
                begin
                    cmd.sort_init = 1'b1;
                    state_next    = S_PASS;
                end
            end
            S_PASS:
            begin
                if (sts.width_lt_n)
                begin
                    cmd.lo_zero = 1'b1;
                    state_next  = S_RUN;
                end
                else
                begin
                    cmd.out_init = 1'b1;
                    state_next   = S_ORD;
                end
            end
            S_RUN:
            begin
                if (sts.lo_lt_n)
                begin
                    cmd.run_init = 1'b1;
                    state_next   = S_MRD;
                end
                else
                begin
                    cmd.pass_next = 1'b1;
                    state_next    = S_PASS;
                end
            end
            S_MRD:
            begin
                state_next = S_MWR;
            end
            S_MWR:
            begin
                cmd.merge_wr = 1'b1;
                if (sts.run_end)
                begin
                    cmd.lo_next = 1'b1;
                    state_next  = S_RUN;
                end
                else
                begin
                    state_next = S_MRD;
                end
            end
            S_ORD:
            begin
                cmd.out_rd = 1'b1;
                state_next = S_OLD;
            end
            S_OLD:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_OWT;
            end
            S_OWT:
            begin
                if (!out_stall)
                begin
                    if (sts.out_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cmd.out_next = 1'b1;
                        state_next   = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/ms_dpath.sv
// Datapath of the merge sorter: two ping-pong RAMs, run indices, compare and
// output register. Depends on ms_pkg and ms_ram.
module ms_dpath #(
    parameter int DEPTH      = ms_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ms_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ms_pkg::cmd_t                 cmd,
    output ms_pkg::sts_t                 sts,
    input  logic signed [DATA_WIDTH-1:0] value,
    output logic signed [DATA_WIDTH-1:0] sorted_value,
    output logic                         final_res,
    output logic                         overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 2;

    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;
    logic [SW-1:0] width_reg, width_next;
    logic          sel_reg, sel_next;      // 0: source is RAM A
    logic [SW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] a_reg, a_next;
    logic [CW-1:0] b_reg, b_next;
    logic [CW-1:0] k_reg, k_next;

    logic signed [DATA_WIDTH-1:0] out_data_reg;
    logic                         out_final_reg;
    logic                         out_ovf_reg;

    logic [SW-1:0] n_ext;
    logic [SW-1:0] mid_sum;
    logic [SW-1:0] hi_sum;
    logic          load_we;
    logic          take_a;

    logic [DATA_WIDTH-1:0] rda0, rda1, rdb0, rdb1;
    logic [DATA_WIDTH-1:0] da, db, merge_data;
    logic [AW-1:0]         raddr0;
    logic                  we_a, we_b;
    logic [AW-1:0]         waddr_a;
    logic [DATA_WIDTH-1:0] wdata_a;

    assign n_ext   = SW'(count_reg);
    assign mid_sum = lo_reg + width_reg;
    assign hi_sum  = lo_reg + (width_reg << 1);
    assign load_we = cmd.load && (count_reg < CW'(DEPTH));

    assign da = sel_reg ? rdb0 : rda0;
    assign db = sel_reg ? rdb1 : rda1;
    assign take_a = (a_reg < mid_reg) &&
                    (!(b_reg < hi_reg) || ($signed(da) < $signed(db)));
    assign merge_data = take_a ? da : db;

    assign sts.width_lt_n = (width_reg < n_ext);
    assign sts.lo_lt_n    = (lo_reg < n_ext);
    assign sts.run_end    = ((k_reg + CW'(1)) == hi_reg);
    assign sts.out_last   = ((k_reg + CW'(1)) == count_reg);

    // Merge writes go to the store that is not the source of this pass
    assign we_a    = load_we || (cmd.merge_wr && sel_reg);
    assign we_b    = cmd.merge_wr && !sel_reg;
    assign waddr_a = cmd.load ? count_reg[AW-1:0] : k_reg[AW-1:0];
    assign wdata_a = cmd.load ? value : merge_data;
    assign raddr0  = cmd.out_rd ? k_reg[AW-1:0] : a_reg[AW-1:0];

    ms_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk    (clk),
        .we     (we_a),
        .waddr  (waddr_a),
        .wdata  (wdata_a),
        .raddr0 (raddr0),
        .raddr1 (b_reg[AW-1:0]),
        .rdata0 (rda0),
        .rdata1 (rda1)
    );

    ms_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk    (clk),
        .we     (we_b),
        .waddr  (k_reg[AW-1:0]),
        .wdata  (merge_data),
        .raddr0 (raddr0),
        .raddr1 (b_reg[AW-1:0]),
        .rdata0 (rdb0),
        .rdata1 (rdb1)
    );

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        width_next   = width_reg;
        sel_next     = sel_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        k_next       = k_reg;

        if (cmd.load)
        begin
            if (load_we)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
        if (cmd.sort_init)
        begin
            width_next = SW'(1);
            sel_next   = 1'b0;
        end
        if (cmd.lo_zero)
        begin
            lo_next = '0;
        end
        if (cmd.run_init)
        begin
            // Clip both run ends to the set size
            mid_next = (mid_sum > n_ext) ? count_reg : mid_sum[CW-1:0];
            hi_next  = (hi_sum > n_ext) ? count_reg : hi_sum[CW-1:0];
            a_next   = lo_reg[CW-1:0];
            b_next   = (mid_sum > n_ext) ? count_reg : mid_sum[CW-1:0];
            k_next   = lo_reg[CW-1:0];
        end
        if (cmd.merge_wr)
        begin
            if (take_a)
            begin
                a_next = a_reg + CW'(1);
            end
            else
            begin
                b_next = b_reg + CW'(1);
            end
            k_next = k_reg + CW'(1);
        end
        if (cmd.lo_next)
        begin
            lo_next = hi_sum;
        end
        if (cmd.pass_next)
        begin
            width_next = width_reg << 1;
            sel_next   = !sel_reg;
        end
        if (cmd.out_init)
        begin
            k_next = '0;
        end
        if (cmd.out_next)
        begin
            k_next = k_reg + CW'(1);
        end
        if (cmd.clear)
        begin
            count_next   = '0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            width_reg   <= '0;
            sel_reg     <= 1'b0;
            lo_reg      <= '0;
            mid_reg     <= '0;
            hi_reg      <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            k_reg       <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            width_reg   <= width_next;
            sel_reg     <= sel_next;
            lo_reg      <= lo_next;
            mid_reg     <= mid_next;
            hi_reg      <= hi_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            k_reg       <= k_next;
        end
    end

    // Output register: hold while the beat waits
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg  <= sel_reg ? rdb0 : rda0;
            out_final_reg <= sts.out_last;
            out_ovf_reg   <= dropped_reg;
        end
    end

    assign sorted_value = out_data_reg;
    assign final_res    = out_final_reg;
    assign overflow     = out_ovf_reg;

endmodule

>>> rtl/core/merge_sorter.sv
// Top level of the merge sorter: controller and datapath.
// Depends on ms_pkg, ms_ctrl, ms_dpath (and through it ms_ram).

// The block collects signed values, one per input beat, into a store of DEPTH
// entries; the beat with last high closes the set. Beats beyond DEPTH are
// dropped, and every result of that set then carries overflow. Loading accepts
// one beat per cycle. The set of n values is then sorted ascending by
// bottom-up merge passes (run widths 1, 2, 4, ...) that ping-pong between two
// RAMs; the single compare-and-write step of the merge handles each element
// as a RAM read, then a compare and write, and ceil(log2 n) passes run. Then
// the n results stream out, each by a RAM read, an output register load and
// a beat; final_res marks the last. Input stall is high from the closing beat
// until the last result beat is taken, so one set is handled at a time.
module merge_sorter #(
    parameter int DEPTH      = ms_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ms_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] sorted_value,
    output logic                         final_res,
    output logic                         overflow
);

    ms_pkg::cmd_t cmd;
    ms_pkg::sts_t sts;

    // Sequence loading, passes and output burst
    ms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last      (last),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold the stores, run indices and output register
    ms_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .value        (value),
        .sorted_value (sorted_value),
        .final_res    (final_res),
        .overflow     (overflow)
    );

endmodule

>>> bench/merge_sorter_check.sv
`timescale 1ns / 100ps
// Checker for the merge sorter: watches both channels, predicts each sorted burst
// and compares it beat by beat. Depends on nothing but its ports.
module merge_sorter_check #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         last,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic signed [DATA_WIDTH-1:0] sorted_value,
    input  logic                         final_res,
    input  logic                         overflow,
    output int                           fails,
    output int                           pending,
    output int                           results_checked,
    output int                           overflow_results
);

    typedef struct {
        logic signed [DATA_WIDTH-1:0] v;
        logic                         fin;
        logic                         ovf;
    } sorted_beat_t;

    logic signed [DATA_WIDTH-1:0] held [DEPTH];
    int           held_count    = 0;
    bit           spilled       = 1'b0;
    sorted_beat_t sorted_due [$];
    int           fail_count    = 0;
    int           pending_count = 0;
    int           checked_count = 0;
    int           ovf_count     = 0;

    assign fails            = fail_count;
    assign pending          = pending_count;
    assign results_checked  = checked_count;
    assign overflow_results = ovf_count;

    // Sort the held set ascending and queue it as one burst.
    task automatic close_set();
        logic signed [DATA_WIDTH-1:0] key;
        int           i;
        int           j;
        sorted_beat_t beat;
        for (i = 1; i < held_count; i++)
        begin
            key = held[i];
            j = i - 1;
            while (j >= 0)
            begin
                if (held[j] <= key)
                    break;
                held[j + 1] = held[j];
                j--;
            end
            held[j + 1] = key;
        end
        for (i = 0; i < held_count; i++)
        begin
            beat.v   = held[i];
            beat.fin = (i == held_count - 1);
            beat.ovf = spilled;
            sorted_due.push_back(beat);
        end
        held_count = 0;
        spilled    = 1'b0;
    endtask

    task automatic absorb_beat(input logic signed [DATA_WIDTH-1:0] v,
                               input logic closes);
        if (held_count < DEPTH)
        begin
            held[held_count] = v;
            held_count++;
        end
        else
            spilled = 1'b1;
        if (closes)
            close_set();
    endtask

    task automatic check_result();
        sorted_beat_t due;
        if (sorted_due.size() == 0)
        begin
            fail_count++;
            $display("%0t: unexpected result: expected none, got value %0d %s %0b %s %0b",
                     $time, sorted_value, "final_res", final_res, "overflow", overflow);
        end
        else
        begin
            due = sorted_due.pop_front();
            if (sorted_value !== due.v || final_res !== due.fin || overflow !== due.ovf)
            begin
                fail_count++;
                $display("%0t: mismatch: expected value %0d final_res %0b overflow %0b,",
                         $time, due.v, due.fin, due.ovf);
                $display("%0t:           got value %0d final_res %0b overflow %0b",
                         $time, sorted_value, final_res, overflow);
            end
            checked_count++;
            if (due.ovf)
                ovf_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                absorb_beat(value, last);
            if (out_valid && !out_stall)
                check_result();
            pending_count = sorted_due.size();
        end
    end

endmodule

>>> bench/merge_sorter_test.sv
`timescale 1ns / 100ps
// Testbench top for the merge sorter: clock, reset, input and output beat traffic
// and the verdict. Depends on ms_pkg, merge_sorter and merge_sorter_check.
module merge_sorter_test;

    localparam int DEPTH        = ms_pkg::DEPTH_DEF;
    localparam int DATA_WIDTH   = ms_pkg::DATA_WIDTH_DEF;
    localparam int RANDOM_BEATS = 460;
    localparam int PHASE_BEATS  = RANDOM_BEATS / 3;
    localparam int HOLD_CYCLES  = 500;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    // How the values of one set are drawn
    typedef enum int {
        FILL_FULL,     // any bit pattern
        FILL_NARROW,   // a few values near zero, many repeats
        FILL_EXTREME,  // range ends, zero, plus and minus one, or any bit pattern
        FILL_FLAT      // one value repeated over the whole set
    } fill_kind_t;

    logic                         clk;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic signed [DATA_WIDTH-1:0] value     = '0;
    logic                         last      = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         final_res;
    logic                         overflow;

    int fails;
    int pending;
    int results_checked;
    int overflow_results;

    // Idle rates in percent per cycle, changed by the stimulus between phases
    int tx_idle_pct = 15;
    int rx_idle_pct = 88;
    // Set by the stimulus to ask the receiver for one long hold-off
    bit hold_now    = 1'b0;

    int beats_sent = 0;
    int sets_sent  = 0;

    merge_sorter #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .final_res    (final_res),
        .overflow     (overflow)
    );

    merge_sorter_check #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .value            (value),
        .last             (last),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .sorted_value     (sorted_value),
        .final_res        (final_res),
        .overflow         (overflow),
        .fails            (fails),
        .pending          (pending),
        .results_checked  (results_checked),
        .overflow_results (overflow_results)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Draw one element of a set. The flat value is fixed per set by the caller.
    function automatic logic signed [DATA_WIDTH-1:0] pick_value(
        input fill_kind_t kind, input logic signed [DATA_WIDTH-1:0] flat);
        logic signed [DATA_WIDTH-1:0] r;
        case (kind)
            FILL_NARROW:
            begin
                r = $urandom_range(0, 6);
                r = r - 3;
            end
            FILL_EXTREME:
            begin
                case ($urandom_range(0, 5))
                    0:       r = VAL_MAX;
                    1:       r = VAL_MIN;
                    2:       r = '0;
                    3:       r = -1;
                    4:       r = 1;
                    default: r = $urandom;
                endcase
            end
            FILL_FLAT: r = flat;
            default:   r = $urandom;
        endcase
        return r;
    endfunction

    // Offer one input beat. Enter and leave at a falling edge. Idle cycles go in
    // front of the beat at the current sender rate; the payload then holds
    // until a rising edge sees stall low.
    task automatic send_beat(input logic signed [DATA_WIDTH-1:0] v, input logic closes);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= closes;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
        @(negedge clk);
    endtask

    // Send a whole set; the last beat closes it.
    task automatic send_set(input int size, input fill_kind_t kind);
        logic signed [DATA_WIDTH-1:0] flat;
        int i;
        flat = $urandom;
        for (i = 0; i < size; i++)
            send_beat(pick_value(kind, flat), i == size - 1);
        sets_sent++;
    endtask

    // Drop valid and wait until every queued result has been taken. Wait for a
    // falling edge before the first check so valid is not assigned twice in the same step.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // Draw a set size: mostly short sets, now and then a full store or one
    // that spills past DEPTH.
    function automatic int pick_size();
        int pct;
        pct = $urandom_range(0, 99);
        if (pct < 70)
            return $urandom_range(1, 10);
        else if (pct < 88)
            return $urandom_range(11, DEPTH - 1);
        else if (pct < 94)
            return DEPTH;
        else
            return $urandom_range(DEPTH + 1, DEPTH + 8);
    endfunction

    function automatic fill_kind_t pick_kind();
        int pct;
        pct = $urandom_range(0, 9);
        if (pct < 5)
            return FILL_FULL;
        else if (pct < 7)
            return FILL_NARROW;
        else if (pct < 9)
            return FILL_EXTREME;
        else
            return FILL_FLAT;
    endfunction

    // Receiver: drive stall at each falling edge at the current rate. On
    // request, hold stall high for a long stretch so the block fills with a
    // closed set and stalls its input while the sender keeps offering beats.
    initial
    begin : receiver
        int held_for;
        forever
        begin
            @(negedge clk);
            if (hold_now)
            begin
                hold_now  = 1'b0;
                held_for  = 0;
                out_stall <= 1'b1;
                while (held_for < HOLD_CYCLES)
                begin
                    @(negedge clk);
                    held_for++;
                end
            end
            else
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Watchdog: end the run if the cycle count passes the limit.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("run stopped at cycle limit with %0d results still expected", pending);
        $display("merge_sorter_test: errors");
        $finish;
    end

    initial
    begin : stimulus
        int         directed_beats;
        int         phase;
        int         phase_end;
        int         size;
        fill_kind_t kind;

        // Hold reset, then release it at a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed sets: single elements at both range ends, a mix of extremes
        // with repeats, a set of equal values, and a descending set of odd size
        // so that the merge passes see uneven runs.
        send_beat(VAL_MAX, 1'b1);
        send_beat(VAL_MIN, 1'b1);
        send_beat(VAL_MAX, 1'b0);
        send_beat(VAL_MIN, 1'b0);
        send_beat('0, 1'b0);
        send_beat(-1, 1'b0);
        send_beat(1, 1'b0);
        send_beat(VAL_MIN, 1'b0);
        send_beat(VAL_MAX, 1'b1);
        repeat (3) send_beat(-7, 1'b0);
        send_beat(-7, 1'b1);
        for (int i = 6; i >= 0; i--)
            send_beat(i * 1000 - 3000, i == 0);
        sets_sent += 5;
        directed_beats = beats_sent;

        // Store-full cases need more than DEPTH beats, so open the random part
        // with them: a set whose closing beat is dropped, a set that exactly
        // fills the store, and a set that spills several beats.
        send_set(DEPTH + 1, FILL_FULL);
        send_set(DEPTH, FILL_NARROW);
        send_set(DEPTH + 6, FILL_EXTREME);

        // Three phases: sender light and receiver heavy on idles, then the
        // reverse, then no idles at all. Pause the sender at each boundary
        // until every result is out; open the last phase with a long hold-off.
        for (phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                drain();
                tx_idle_pct = 88;
                rx_idle_pct = 15;
            end
            else if (phase == 2)
            begin
                drain();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_now    = 1'b1;
            end
            phase_end = (phase == 2) ? RANDOM_BEATS : PHASE_BEATS * (phase + 1);
            while (beats_sent - directed_beats < phase_end)
            begin
                size = pick_size();
                kind = pick_kind();
                send_set(size, kind);
            end
        end

        // Let the last burst come out, then allow a few quiet cycles
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d beats in %0d sets, %0d sorted results compared, %0d with overflow",
                 beats_sent, sets_sent, results_checked, overflow_results);
        if (fails == 0 && pending == 0)
            $display("merge_sorter_test: clean");
        else
            $display("merge_sorter_test: errors");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/ms_pkg.sv
rtl/core/ms_ram.sv
rtl/core/ms_ctrl.sv
rtl/core/ms_dpath.sv
rtl/core/merge_sorter.sv
bench/merge_sorter_check.sv
bench/merge_sorter_test.sv
